// ----- hw/rtl/mst_pkg.sv -----
// Shared types and constants for the multi-slot one-shot timer.
// Holds field widths, command and status codes and the slot unit result.
// No dependencies.
package mst_pkg;

   localparam int DUR_W  = 31;
   localparam int SLOT_W = 4;
   localparam int TAG_W  = 16;
   localparam int HID_W  = 8;
   localparam int STAT_W = 3;
   localparam int CNT_W  = 4;

   localparam logic [CNT_W-1:0] PEND_MAX       = 4'd15;
   localparam logic [DUR_W-1:0] MAX_PERIOD_RST = 31'd8000000;

   typedef enum logic [1:0] {
      CMD_SET    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_PERIOD = 2'd2,
      CMD_TAKE   = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STS_SET_OK      = 3'd0,
      STS_SET_FULL    = 3'd1,
      STS_REMOVE_DONE = 3'd2,
      STS_PERIOD_DONE = 3'd3,
      STS_GIVEN       = 3'd4,
      STS_NONE        = 3'd5
   } status_type;

   // Result of the shared subtract/compare unit
   typedef struct packed {
      logic             lt;       // a below b
      logic             expire;   // a not above b
      logic [DUR_W-1:0] diff;     // a minus b
      logic             shorter;  // diff below best
   } alu_res_type;

endpackage

// ----- hw/rtl/multi_slot_oneshot_timer.sv -----
// Multi-slot one-shot timer: one hardware period shared by SLOT_COUNT slots.
// Depends on mst_pkg and mst_slot_alu.
//
// Usage:
//   req_* carries one command per beat (set, remove, period end, take next).
//   A beat is taken when req_valid is high and req_stall is low. rsp_* returns
//   exactly one result beat per command, taken when rsp_valid is high and
//   rsp_stall is low. csr_* writes max_period_us; csr_ready is always high and
//   a new maximum is used from the next period end on.
// Sequencing:
//   Set, period end and take walk the slots one per cycle through a single
//   subtract/compare unit; remove acts on its own slot directly. Set and take
//   stop at the first slot that fits, while period end always walks every slot.
//   req_stall stays high from accept until the result is moved to the output
//   register, so no new command is accepted before the result is loaded.
// Reset:
//   Synchronous, active high. All slots free, period and maximum 8000000 us,
//   scan position and expired count zero. No clearing pass is needed.
// Stall:
//   A held result keeps its output register; the next command may be
//   accepted and run, and waits to load its result until that beat is taken.
module multi_slot_oneshot_timer #(
   parameter int SLOT_COUNT = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_cmd,
   input  logic [mst_pkg::DUR_W-1:0]          req_duration_us,
   input  logic [mst_pkg::SLOT_W-1:0]         req_slot_id,
   input  logic signed [mst_pkg::TAG_W-1:0]   req_tag_value,
   input  logic [mst_pkg::HID_W-1:0]          req_handler_id,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mst_pkg::STAT_W-1:0]         rsp_status,
   output logic [mst_pkg::SLOT_W-1:0]         rsp_slot_index,
   output logic signed [mst_pkg::TAG_W-1:0]   rsp_out_tag_value,
   output logic [mst_pkg::HID_W-1:0]          rsp_out_handler_id,
   output logic [mst_pkg::DUR_W-1:0]          rsp_period_us,
   output logic                               rsp_period_changed,
   output logic [mst_pkg::CNT_W-1:0]          rsp_expired_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mst_pkg::DUR_W-1:0]          csr_max_period_us
);
   import mst_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(SLOT_COUNT);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type                state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic [DUR_W-1:0]         dur_ff, dur_in;
   logic [SLOT_W-1:0]        sid_ff, sid_in;
   logic signed [TAG_W-1:0]  tag_ff, tag_in;
   logic [HID_W-1:0]         hid_ff, hid_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [DUR_W-1:0]         best_ff, best_in;
   logic [DUR_W-1:0]         max_ff, max_in;
   logic [DUR_W-1:0]         period_ff, period_in;
   logic [CNT_W-1:0]         scan_ff, scan_in;
   logic [CNT_W-1:0]         pend_ff, pend_in;

   status_type               res_status_ff, res_status_in;
   logic [SLOT_W-1:0]        res_slot_ff, res_slot_in;
   logic signed [TAG_W-1:0]  res_tag_ff, res_tag_in;
   logic [HID_W-1:0]         res_hid_ff, res_hid_in;
   logic                     res_changed_ff, res_changed_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic signed [TAG_W-1:0]  rsp_tag_ff, rsp_tag_in;
   logic [HID_W-1:0]         rsp_hid_ff, rsp_hid_in;
   logic [DUR_W-1:0]         rsp_period_ff, rsp_period_in;
   logic                     rsp_changed_ff, rsp_changed_in;
   logic [CNT_W-1:0]         rsp_pend_ff, rsp_pend_in;

   logic                     free_ff [SLOT_COUNT];
   logic                     free_in [SLOT_COUNT];
   logic [DUR_W-1:0]         rem_ff [SLOT_COUNT];
   logic [DUR_W-1:0]         rem_in [SLOT_COUNT];
   logic signed [TAG_W-1:0]  slot_tag_ff [SLOT_COUNT];
   logic signed [TAG_W-1:0]  slot_tag_in [SLOT_COUNT];
   logic [HID_W-1:0]         slot_hid_ff [SLOT_COUNT];
   logic [HID_W-1:0]         slot_hid_in [SLOT_COUNT];

   logic [IDX_W-1:0]         idx;
   logic [IDX_W-1:0]         sid_idx;
   logic                     in_range;
   logic [DUR_W-1:0]         cap;
   logic [DUR_W-1:0]         alu_a;
   alu_res_type              alu_res;

   assign idx      = cnt_ff[IDX_W-1:0];
   assign sid_idx  = sid_ff[IDX_W-1:0];
   assign in_range = cnt_ff < SLOT_END;
   assign cap      = (max_ff == '0) ? DUR_W'(1) : max_ff;
   assign alu_a    = (cmd_ff == CMD_SET) ? dur_ff : rem_ff[idx];

   mst_slot_alu u_alu (
      .a_value    (alu_a),
      .b_value    (period_ff),
      .best_value (best_ff),
      .res        (alu_res)
   );

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      dur_in         = dur_ff;
      sid_in         = sid_ff;
      tag_in         = tag_ff;
      hid_in         = hid_ff;
      cnt_in         = cnt_ff;
      best_in        = best_ff;
      max_in         = max_ff;
      period_in      = period_ff;
      scan_in        = scan_ff;
      pend_in        = pend_ff;
      res_status_in  = res_status_ff;
      res_slot_in    = res_slot_ff;
      res_tag_in     = res_tag_ff;
      res_hid_in     = res_hid_ff;
      res_changed_in = res_changed_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_hid_in     = rsp_hid_ff;
      rsp_period_in  = rsp_period_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_pend_in    = rsp_pend_ff;
      free_in        = free_ff;
      rem_in         = rem_ff;
      slot_tag_in    = slot_tag_ff;
      slot_hid_in    = slot_hid_ff;

      if (csr_valid) begin
         max_in = csr_max_period_us;
      end

      // drop the output beat once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in         = cmd_type'(req_cmd);
               dur_in         = (req_duration_us == '0) ? DUR_W'(1) : req_duration_us;
               sid_in         = req_slot_id;
               tag_in         = req_tag_value;
               hid_in         = req_handler_id;
               cnt_in         = (cmd_type'(req_cmd) == CMD_TAKE) ? scan_ff : '0;
               best_in        = cap;
               res_status_in  = STS_NONE;
               res_slot_in    = '0;
               res_tag_in     = '0;
               res_hid_in     = '0;
               res_changed_in = 1'b0;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            unique case (cmd_ff)
               CMD_SET: begin
                  if (!in_range) begin
                     res_status_in = STS_SET_FULL;
                     state_in      = S_DONE;
                  end else if (free_ff[idx]) begin
                     free_in[idx]     = 1'b0;
                     rem_in[idx]      = dur_ff;
                     slot_tag_in[idx] = tag_ff;
                     slot_hid_in[idx] = hid_ff;
                     res_status_in    = STS_SET_OK;
                     res_slot_in      = cnt_ff;
                     // shorten the period when the new slot ends first
                     if (alu_res.lt) begin
                        period_in      = dur_ff;
                        res_changed_in = 1'b1;
                     end
                     state_in = S_DONE;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               CMD_REMOVE: begin
                  if (sid_ff < SLOT_END) begin
                     free_in[sid_idx] = 1'b1;
                  end
                  res_status_in = STS_REMOVE_DONE;
                  state_in      = S_DONE;
               end
               CMD_PERIOD: begin
                  if (!in_range) begin
                     period_in      = best_ff;
                     res_changed_in = 1'b1;
                     scan_in        = '0;
                     res_status_in  = STS_PERIOD_DONE;
                     state_in       = S_DONE;
                  end else begin
                     if (!free_ff[idx] && rem_ff[idx] != '0) begin
                        if (alu_res.expire) begin
                           rem_in[idx] = '0;
                           if (pend_ff != PEND_MAX) begin
                              pend_in = pend_ff + 1'b1;
                           end
                        end else begin
                           rem_in[idx] = alu_res.diff;
                           if (alu_res.shorter) begin
                              best_in = alu_res.diff;
                           end
                        end
                     end
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               CMD_TAKE: begin
                  if (!in_range) begin
                     scan_in       = SLOT_END;
                     res_status_in = STS_NONE;
                     state_in      = S_DONE;
                  end else if (!free_ff[idx] && rem_ff[idx] == '0) begin
                     free_in[idx] = 1'b1;
                     if (pend_ff != '0) begin
                        pend_in = pend_ff - 1'b1;
                     end
                     res_status_in = STS_GIVEN;
                     res_slot_in   = cnt_ff;
                     res_tag_in    = slot_tag_ff[idx];
                     res_hid_in    = slot_hid_ff[idx];
                     scan_in       = cnt_ff;
                     state_in      = S_DONE;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_slot_in    = res_slot_ff;
               rsp_tag_in     = res_tag_ff;
               rsp_hid_in     = res_hid_ff;
               rsp_period_in  = period_ff;
               rsp_changed_in = res_changed_ff;
               rsp_pend_in    = pend_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_ff       <= MAX_PERIOD_RST;
         period_ff    <= MAX_PERIOD_RST;
         scan_ff      <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            free_ff[i] <= 1'b1;
         end
      end else begin
         state_ff     <= state_in;
         max_ff       <= max_in;
         period_ff    <= period_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         free_ff      <= free_in;
      end
      cmd_ff         <= cmd_in;
      dur_ff         <= dur_in;
      sid_ff         <= sid_in;
      tag_ff         <= tag_in;
      hid_ff         <= hid_in;
      cnt_ff         <= cnt_in;
      best_ff        <= best_in;
      res_status_ff  <= res_status_in;
      res_slot_ff    <= res_slot_in;
      res_tag_ff     <= res_tag_in;
      res_hid_ff     <= res_hid_in;
      res_changed_ff <= res_changed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_hid_ff     <= rsp_hid_in;
      rsp_period_ff  <= rsp_period_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_pend_ff    <= rsp_pend_in;
      rem_ff         <= rem_in;
      slot_tag_ff    <= slot_tag_in;
      slot_hid_ff    <= slot_hid_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot_index     = rsp_slot_ff;
   assign rsp_out_tag_value  = rsp_tag_ff;
   assign rsp_out_handler_id = rsp_hid_ff;
   assign rsp_period_us      = rsp_period_ff;
   assign rsp_period_changed = rsp_changed_ff;
   assign rsp_expired_count  = rsp_pend_ff;

endmodule

// ----- hw/rtl/mst_slot_alu.sv -----
// Shared subtract and compare unit of the slot sequencer.
// One 32-bit subtract plus one compare against the running minimum.
// Depends on mst_pkg.
module mst_slot_alu (
   input  logic [mst_pkg::DUR_W-1:0] a_value,
   input  logic [mst_pkg::DUR_W-1:0] b_value,
   input  logic [mst_pkg::DUR_W-1:0] best_value,
   output mst_pkg::alu_res_type      res
);
   import mst_pkg::*;

   logic [DUR_W:0] diff_w;

   assign diff_w      = {1'b0, a_value} - {1'b0, b_value};
   assign res.lt      = diff_w[DUR_W];
   assign res.expire  = diff_w[DUR_W] || (diff_w[DUR_W-1:0] == '0);
   assign res.diff    = diff_w[DUR_W-1:0];
   assign res.shorter = diff_w[DUR_W-1:0] < best_value;

endmodule

// ----- hw/rtl/mst_check.sv -----
// Port-level checks for the multi-slot one-shot timer, bound to the top level.
// Depends on mst_pkg and multi_slot_oneshot_timer.
module mst_check (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [mst_pkg::STAT_W-1:0]         rsp_status,
   input logic [mst_pkg::SLOT_W-1:0]         rsp_slot_index,
   input logic [mst_pkg::DUR_W-1:0]          rsp_period_us,
   input logic                               rsp_period_changed
);
   import mst_pkg::*;

   // a held beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_period_us))
      else $error("rsp beat changed while stalled");

   // every command passes through the scan state, so an accept is always followed by stall
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req accepted on back-to-back cycles");

   a_period_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_period_us != '0)
      else $error("programmed period is zero");

   a_period_end_changes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STS_PERIOD_DONE) |-> rsp_period_changed)
      else $error("period end without reprogram");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STS_SET_OK) && (rsp_status != STS_GIVEN)
         |-> (rsp_slot_index == '0) && !(rsp_period_changed
         && (rsp_status != STS_PERIOD_DONE)))
      else $error("slot index or change flag set on wrong status");

endmodule

bind multi_slot_oneshot_timer mst_check u_mst_check (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_slot_index     (rsp_slot_index),
   .rsp_period_us      (rsp_period_us),
   .rsp_period_changed (rsp_period_changed)
);
